// File: design/burh_pkg.sv
// ----------------------------------------------------------------------------
// burh_pkg
// Shared types, codes and helpers of the bounded undo/redo history block.
// ----------------------------------------------------------------------------
package burh_pkg;

    // operation codes of an input item
    localparam logic [1:0] OP_RECORD = 2'd0;
    localparam logic [1:0] OP_UNDO   = 2'd1;
    localparam logic [1:0] OP_REDO   = 2'd2;

    // entry kinds
    localparam logic [2:0] KIND_INVALID  = 3'd0;
    localparam logic [2:0] KIND_INSERT   = 3'd1;
    localparam logic [2:0] KIND_DELETE   = 3'd2;
    localparam logic [2:0] KIND_ADD_LINE = 3'd3;
    localparam logic [2:0] KIND_DEL_LINE = 3'd4;

    // entries of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // work handed from the front part to the back part
    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_UNDO  = 2'd1,
        ACT_REDO  = 2'd2,
        ACT_EMPTY = 2'd3
    } action_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] pos;
        logic [31:0] line;
        logic [7:0]  symbol;
        logic [31:0] editor;
        logic [31:0] seq_no;
    } entry_t;

    function automatic logic [2:0] invert_kind(input logic [2:0] kind);
        logic [2:0] res;
        case (kind)
            KIND_INSERT:   res = KIND_DELETE;
            KIND_DELETE:   res = KIND_INSERT;
            KIND_ADD_LINE: res = KIND_DEL_LINE;
            KIND_DEL_LINE: res = KIND_ADD_LINE;
            default:       res = KIND_INVALID;
        endcase
        return res;
    endfunction

endpackage

// File: design/bounded_undo_redo_history.sv
// ----------------------------------------------------------------------------
// bounded_undo_redo_history
// Ring-buffered edit history with undo and redo around a cursor.
// ----------------------------------------------------------------------------
// A record transaction drops everything above the cursor and appends the
// edit, overwriting the oldest entry once HISTORY_DEPTH entries are held; it
// gives no result. Undo and redo transactions each give one result. The front
// part updates cursor, count and oldest index in the cycle of acceptance and
// queues a command; the back part performs it on a single history RAM with
// one write and one registered read port. Records are accepted back to back
// while the two-entry command queue has room. An undo or redo reads the RAM
// and then loads the result register, and the next one starts only once
// that register has been taken and has emptied. A result passes through the
// command queue and the result register, with the RAM read between them when
// an entry is read, and comes later when earlier commands wait ahead of it.
// The memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module bounded_undo_redo_history #(
    parameter int HISTORY_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  operation,
    input  logic [2:0]  entry_kind,
    input  logic [31:0] char_pos,
    input  logic [31:0] line_index,
    input  logic [7:0]  symbol,
    input  logic [31:0] editor_id,
    input  logic [31:0] sequence_id,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [2:0]  result_kind,
    output logic [31:0] result_pos,
    output logic [31:0] result_line,
    output logic [7:0]  result_symbol,
    output logic [31:0] result_editor,
    output logic [31:0] result_sequence
);

    import burh_pkg::*;

    localparam int PTR_W   = $clog2(HISTORY_DEPTH);
    localparam int ENTRY_W = $bits(entry_t);
    localparam int CMD_W   = $bits(action_t) + PTR_W + ENTRY_W;

    entry_t           item_entry, res_entry;
    logic             f_cmd_valid, f_cmd_ready;
    action_t          f_cmd_action, b_cmd_action;
    logic [PTR_W-1:0] f_cmd_slot, b_cmd_slot;
    entry_t           f_cmd_entry, b_cmd_entry;
    logic [CMD_W-1:0] push_data, pop_data;
    logic             b_cmd_valid, b_cmd_pop;
    logic             ram_wr_en, ram_rd_en;
    logic [PTR_W-1:0] ram_wr_addr, ram_rd_addr;
    entry_t           ram_wr_data, ram_rd_data;

    assign item_entry.kind   = entry_kind;
    assign item_entry.pos    = char_pos;
    assign item_entry.line   = line_index;
    assign item_entry.symbol = symbol;
    assign item_entry.editor = editor_id;
    assign item_entry.seq_no = sequence_id;

    burh_front #(
        .DEPTH (HISTORY_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .operation  (operation),
        .item_entry (item_entry),
        .cmd_valid  (f_cmd_valid),
        .cmd_ready  (f_cmd_ready),
        .cmd_action (f_cmd_action),
        .cmd_slot   (f_cmd_slot),
        .cmd_entry  (f_cmd_entry)
    );

    assign push_data = {f_cmd_action, f_cmd_slot, f_cmd_entry};

    burh_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_cmd_valid),
        .push_ready (f_cmd_ready),
        .push_data  (push_data),
        .pop_valid  (b_cmd_valid),
        .pop_ready  (b_cmd_pop),
        .pop_data   (pop_data)
    );

    assign b_cmd_action = action_t'(pop_data[CMD_W-1 -: $bits(action_t)]);
    assign b_cmd_slot   = pop_data[ENTRY_W +: PTR_W];
    assign b_cmd_entry  = entry_t'(pop_data[ENTRY_W-1:0]);

    burh_back #(
        .DEPTH (HISTORY_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (b_cmd_valid),
        .cmd_pop     (b_cmd_pop),
        .cmd_action  (b_cmd_action),
        .cmd_slot    (b_cmd_slot),
        .cmd_entry   (b_cmd_entry),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .res_valid   (result_valid),
        .res_ready   (result_ready),
        .res_entry   (res_entry)
    );

    burh_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign result_kind     = res_entry.kind;
    assign result_pos      = res_entry.pos;
    assign result_line     = res_entry.line;
    assign result_symbol   = res_entry.symbol;
    assign result_editor   = res_entry.editor;
    assign result_sequence = res_entry.seq_no;

endmodule

// File: design/burh_ram.sv
// ----------------------------------------------------------------------------
// burh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module burh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/burh_queue.sv
// ----------------------------------------------------------------------------
// burh_queue
// Short first-in first-out command queue between the front and back parts.
// ----------------------------------------------------------------------------
module burh_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/burh_front.sv
// ----------------------------------------------------------------------------
// burh_front
// Accepts items, keeps cursor, count and oldest index, and turns each record,
// undo or redo into a write, a read or an empty-result command for the back part.
// ----------------------------------------------------------------------------
module burh_front #(
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  logic [1:0]               operation,
    input  burh_pkg::entry_t         item_entry,
    output logic                     cmd_valid,
    input  logic                     cmd_ready,
    output burh_pkg::action_t        cmd_action,
    output logic [$clog2(DEPTH)-1:0] cmd_slot,
    output burh_pkg::entry_t         cmd_entry
);

    import burh_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;

    logic [PTR_W-1:0] oldest_reg, oldest_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] cursor_reg, cursor_next;
    logic [CNT_W-1:0] offset;
    logic [SUM_W-1:0] slot_sum, slot_wrap;
    logic             accept, has_cmd, full;

    // ring position of the entry that lies offset places above the oldest
    assign slot_sum  = {1'b0, oldest_reg} + SUM_W'(offset);
    assign slot_wrap = (slot_sum >= SUM_W'(DEPTH)) ? slot_sum - SUM_W'(DEPTH) : slot_sum;
    assign full      = (cursor_reg == CNT_W'(DEPTH));

    assign item_ready = cmd_ready;
    assign accept     = item_valid && item_ready;
    assign cmd_valid  = item_valid && has_cmd;
    assign cmd_entry  = item_entry;

    always_comb
    begin
        oldest_next = oldest_reg;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        offset      = cursor_reg;
        has_cmd     = 1'b0;
        cmd_action  = ACT_EMPTY;
        cmd_slot    = slot_wrap[PTR_W-1:0];
        case (operation)
            OP_RECORD:
            begin
                has_cmd    = 1'b1;
                cmd_action = ACT_WRITE;
                // everything above the cursor is dropped first
                count_next = cursor_reg;
                if (full)
                begin
                    cmd_slot    = oldest_reg;
                    oldest_next = (oldest_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                     : oldest_reg + 1'b1;
                end
                else
                begin
                    count_next  = cursor_reg + 1'b1;
                    cursor_next = cursor_reg + 1'b1;
                end
            end
            OP_UNDO:
            begin
                has_cmd = 1'b1;
                if (cursor_reg != '0)
                begin
                    offset      = cursor_reg - 1'b1;
                    cursor_next = cursor_reg - 1'b1;
                    cmd_action  = ACT_UNDO;
                end
            end
            OP_REDO:
            begin
                has_cmd = 1'b1;
                if (cursor_reg < count_reg)
                begin
                    cursor_next = cursor_reg + 1'b1;
                    cmd_action  = ACT_REDO;
                end
            end
            default:
            begin
                has_cmd = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg <= '0;
            count_reg  <= '0;
            cursor_reg <= '0;
        end
        else if (accept)
        begin
            oldest_reg <= oldest_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
        end
    end

    a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (cursor_reg <= count_reg) && (count_reg <= CNT_W'(DEPTH)))
        else $error("history cursor or count out of range");

    a_oldest_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && (operation == OP_RECORD) && full) |=> $stable(oldest_reg))
        else $error("oldest index moved without a record into a full history");

endmodule

// File: design/burh_back.sv
// ----------------------------------------------------------------------------
// burh_back
// Carries out queued commands on the history memory and holds the result
// register of the output channel.
// ----------------------------------------------------------------------------
module burh_back #(
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_pop,
    input  burh_pkg::action_t        cmd_action,
    input  logic [$clog2(DEPTH)-1:0] cmd_slot,
    input  burh_pkg::entry_t         cmd_entry,
    output logic                     ram_wr_en,
    output logic [$clog2(DEPTH)-1:0] ram_wr_addr,
    output burh_pkg::entry_t         ram_wr_data,
    output logic                     ram_rd_en,
    output logic [$clog2(DEPTH)-1:0] ram_rd_addr,
    input  burh_pkg::entry_t         ram_rd_data,
    output logic                     res_valid,
    input  logic                     res_ready,
    output burh_pkg::entry_t         res_entry
);

    import burh_pkg::*;

    logic   rd_pend_reg, rd_pend_next;
    logic   rd_inv_reg;
    logic   out_valid_reg, out_valid_next;
    entry_t out_entry_reg, out_entry_next;
    logic   result_free, is_write, load_empty;

    // reads and empty results wait for a free result register
    assign result_free = !rd_pend_reg && !out_valid_reg;
    assign is_write    = (cmd_action == ACT_WRITE);
    assign cmd_pop     = cmd_valid && (is_write || result_free);
    assign load_empty  = cmd_pop && (cmd_action == ACT_EMPTY);

    assign ram_wr_en   = cmd_pop && is_write;
    assign ram_wr_addr = cmd_slot;
    assign ram_wr_data = cmd_entry;
    assign ram_rd_en   = cmd_pop && ((cmd_action == ACT_UNDO) || (cmd_action == ACT_REDO));
    assign ram_rd_addr = cmd_slot;

    assign res_valid = out_valid_reg;
    assign res_entry = out_entry_reg;

    always_comb
    begin
        rd_pend_next   = ram_rd_en;
        out_valid_next = out_valid_reg && !res_ready;
        out_entry_next = out_entry_reg;
        if (rd_pend_reg)
        begin
            out_valid_next = 1'b1;
            out_entry_next = ram_rd_data;
            if (rd_inv_reg)
            begin
                out_entry_next.kind = invert_kind(ram_rd_data.kind);
            end
        end
        else if (load_empty)
        begin
            out_valid_next = 1'b1;
            out_entry_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_entry_reg <= out_entry_next;
        if (ram_rd_en)
        begin
            rd_inv_reg <= (cmd_action == ACT_UNDO);
        end
    end

    a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |=> out_valid_reg)
        else $error("memory read did not reach the result register");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> !out_valid_reg)
        else $error("read data would overwrite a waiting result");

endmodule

// File: tb/tb_bounded_undo_redo_history.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bounded_undo_redo_history
// Self-checking bench for the bounded undo/redo edit history.
// A checker class keeps its own ring, cursor and count, predicts the result
// of every undo and redo, and compares each result transaction field by
// field. Directed edits cover the empty ends, every kind and the ignored
// operation code; random episodes of record, undo and redo bursts fill and
// wrap the ring. Both sides idle at random, with one long result stall.
// ----------------------------------------------------------------------------
module tb_bounded_undo_redo_history;
    import burh_pkg::*;

    localparam int          HIST_DEPTH   = 64;
    localparam logic [1:0]  OP_IGNORED   = 2'd3;
    localparam int          RANDOM_ITEMS = 1200;
    localparam int          LONG_HOLD    = 400;
    localparam int          CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] pos;
        logic [31:0] line;
        logic [7:0]  symbol;
        logic [31:0] editor;
        logic [31:0] seq_no;
    } edit_rec_t;

    class history_checker;
        edit_rec_t   ring [HIST_DEPTH];
        logic [5:0]  oldest;
        logic [6:0]  count;
        logic [6:0]  cursor;
        edit_rec_t   expected_results [$];
        int unsigned mismatches;

        function new();
            oldest = '0;
            count = '0;
            cursor = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void queue_expected(input edit_rec_t r);
            expected_results.insert(expected_results.size(), r);
        endfunction

        task report(input string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        // inserts and line adds pair with the next code up
        function logic [2:0] undone_kind(input logic [2:0] k);
            if (k >= KIND_INSERT && k <= KIND_DEL_LINE)
                return k[0] ? k + 3'd1 : k - 3'd1;
            return KIND_INVALID;
        endfunction

        // ring of 64, so 6-bit slot arithmetic wraps like the modulo
        function void note_item(input logic [1:0] op, input edit_rec_t e);
            logic [5:0] slot;
            edit_rec_t  res;
            case (op)
                OP_RECORD:
                begin
                    count = cursor;
                    if (count < HIST_DEPTH)
                    begin
                        slot = oldest + count[5:0];
                        count++;
                        cursor++;
                    end
                    else
                    begin
                        slot = oldest;
                        oldest = oldest + 6'd1;
                    end
                    ring[slot] = e;
                end
                OP_UNDO:
                begin
                    if (cursor == 0)
                        queue_expected('0);
                    else
                    begin
                        cursor--;
                        slot = oldest + cursor[5:0];
                        res = ring[slot];
                        res.kind = undone_kind(res.kind);
                        queue_expected(res);
                    end
                end
                OP_REDO:
                begin
                    if (cursor >= count)
                        queue_expected('0);
                    else
                    begin
                        slot = oldest + cursor[5:0];
                        cursor++;
                        queue_expected(ring[slot]);
                    end
                end
                default:
                    ;
            endcase
        endfunction

        task check_result(input edit_rec_t got);
            edit_rec_t want;
            if (expected_results.size() == 0)
            begin
                report($sformatf("unexpected result kind %0d pos %h", got.kind, got.pos));
                return;
            end
            want = expected_results[0];
            expected_results.delete(0);
            if (got.kind !== want.kind)
                report($sformatf("result_kind %0d, want %0d", got.kind, want.kind));
            if (got.pos !== want.pos)
                report($sformatf("result_pos %h, want %h", got.pos, want.pos));
            if (got.line !== want.line)
                report($sformatf("result_line %h, want %h", got.line, want.line));
            if (got.symbol !== want.symbol)
                report($sformatf("result_symbol %h, want %h", got.symbol, want.symbol));
            if (got.editor !== want.editor)
                report($sformatf("result_editor %h, want %h", got.editor, want.editor));
            if (got.seq_no !== want.seq_no)
                report($sformatf("result_sequence %h, want %h", got.seq_no, want.seq_no));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic [1:0]  operation = OP_RECORD;
    logic [2:0]  entry_kind = KIND_INVALID;
    logic [31:0] char_pos = '0;
    logic [31:0] line_index = '0;
    logic [7:0]  symbol = '0;
    logic [31:0] editor_id = '0;
    logic [31:0] sequence_id = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [2:0]  result_kind;
    logic [31:0] result_pos;
    logic [31:0] result_line;
    logic [7:0]  result_symbol;
    logic [31:0] result_editor;
    logic [31:0] result_sequence;

    history_checker book = new();
    bit             calm = 1'b0;
    bit             hold_request = 1'b0;
    int unsigned    accepted = 0;
    int unsigned    cycles = 0;

    bounded_undo_redo_history #(
        .HISTORY_DEPTH(HIST_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .operation(operation),
        .entry_kind(entry_kind),
        .char_pos(char_pos),
        .line_index(line_index),
        .symbol(symbol),
        .editor_id(editor_id),
        .sequence_id(sequence_id),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result_kind(result_kind),
        .result_pos(result_pos),
        .result_line(result_line),
        .result_symbol(result_symbol),
        .result_editor(result_editor),
        .result_sequence(result_sequence)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** bounded_undo_redo_history: FAILED **");
            $finish;
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic edit_rec_t random_edit();
        edit_rec_t e;
        e.kind   = 3'($urandom_range(0, 7));
        e.pos    = pick_word();
        e.line   = pick_word();
        e.symbol = 8'($urandom_range(0, 255));
        e.editor = pick_word();
        e.seq_no = pick_word();
        return e;
    endfunction

    task automatic send_item(input logic [1:0] op, input edit_rec_t e);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 70)
            gap = 0;
        else if (r < 95)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid  <= 1'b1;
        operation   <= op;
        entry_kind  <= e.kind;
        char_pos    <= e.pos;
        line_index  <= e.line;
        symbol      <= e.symbol;
        editor_id   <= e.editor;
        sequence_id <= e.seq_no;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        book.note_item(op, e);
        if (op != OP_IGNORED)
            accepted++;
    endtask

    task automatic send_burst(input logic [1:0] op, input int n);
        repeat (n) send_item(op, random_edit());
    endtask

    // result side: checks transactions and paces result_ready
    initial
    begin : result_side
        int hold_left;
        int r;
        bit eager;
        hold_left = 0;
        eager = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
                book.check_result({result_kind, result_pos, result_line, result_symbol,
                                   result_editor, result_sequence});
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
                result_ready <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 299) == 0)
                    eager = !eager;
                r = $urandom_range(0, 99);
                if (eager || r < 80)
                    result_ready <= 1'b1;
                else if (r < 97)
                begin
                    hold_left = $urandom_range(0, 3);
                    result_ready <= 1'b0;
                end
                else
                begin
                    hold_left = $urandom_range(20, 80);
                    result_ready <= 1'b0;
                end
            end
        end
    end

    initial
    begin : item_side
        edit_rec_t e;
        int        n;
        bit        stalled;
        bit        drained;
        stalled = 1'b0;
        drained = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // both ends empty, then the code that does nothing
        send_item(OP_UNDO, random_edit());
        send_item(OP_REDO, random_edit());
        send_item(OP_IGNORED, random_edit());
        // every kind, fields at zero, all ones or random
        for (int k = 0; k < 8; k++)
        begin
            e = random_edit();
            e.kind = 3'(k);
            if (k % 3 == 0)
                e = {e.kind, {(32 + 32 + 8 + 32 + 32){1'b0}}};
            else if (k % 3 == 1)
                e = {e.kind, {(32 + 32 + 8 + 32 + 32){1'b1}}};
            send_item(OP_RECORD, e);
        end
        // undo past the bottom, redo two, record drops the rest
        send_burst(OP_UNDO, 9);
        send_burst(OP_REDO, 2);
        e = random_edit();
        e.kind = KIND_INSERT;
        send_item(OP_RECORD, e);
        send_item(OP_REDO, random_edit());
        send_item(OP_UNDO, random_edit());

        accepted = 0;
        while (accepted < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 5) == 0);
            if (!stalled && accepted >= 400)
            begin
                // results back up while items keep coming
                stalled = 1'b1;
                calm = 1'b1;
                hold_request = 1'b1;
                for (int i = 0; i < 30; i++)
                    send_item($urandom_range(0, 1) ? OP_UNDO : OP_REDO, random_edit());
            end
            if (!drained && accepted >= 800)
            begin
                drained = 1'b1;
                item_valid <= 1'b0;
                while (book.pending() != 0) @(posedge clk);
            end
            case ($urandom_range(0, 9))
                0, 1, 2:
                    send_burst(OP_RECORD, ($urandom_range(0, 5) == 0) ?
                               $urandom_range(60, 90) : $urandom_range(1, 12));
                3, 4:
                    send_burst(OP_UNDO, ($urandom_range(0, 5) == 0) ?
                               $urandom_range(40, 70) : $urandom_range(1, 20));
                5:
                    send_burst(OP_REDO, $urandom_range(1, 20));
                6:
                begin
                    n = $urandom_range(1, 10);
                    send_burst(OP_UNDO, n);
                    send_burst(OP_REDO, $urandom_range(0, n));
                    send_burst(OP_RECORD, $urandom_range(1, 5));
                end
                default:
                    repeat ($urandom_range(1, 15))
                        send_item(2'($urandom_range(0, 3)), random_edit());
            endcase
        end
        item_valid <= 1'b0;

        while (book.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (book.pending() != 0)
            book.report($sformatf("%0d results never arrived", book.pending()));
        if (book.mismatches == 0)
            $display("** bounded_undo_redo_history: PASSED **");
        else
            $display("** bounded_undo_redo_history: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
design/burh_pkg.sv
design/burh_ram.sv
design/burh_queue.sv
design/burh_front.sv
design/burh_back.sv
design/bounded_undo_redo_history.sv
tb/tb_bounded_undo_redo_history.sv
